// File: hdl/rxb_pkg.sv
package rxb_pkg;

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES  = 2'd1;

  // Reset values of the configuration registers; the key is "!@#".
  localparam logic [2:0]  KEY_LENGTH_RESET = 3'd3;
  localparam logic [31:0] KEY_BYTES_RESET  = 32'h0023_4021;

  localparam logic [7:0] ROT_AMOUNT = 8'd13;
  localparam logic [7:0] PAD_CHAR   = 8'h3D;

  // Maximum number of characters one byte can produce.
  localparam int GROUP_CHARS = 4;

  // Characters produced by one byte, handed from the encoder to the output buffer.
  typedef struct packed {
    logic [GROUP_CHARS-1:0][7:0] chars;
    logic [2:0]                  cnt;
    logic                        last;
  } rxb_group_t;

  // Letters are rotated by 13 within their own case; other bytes pass.
  function automatic logic [7:0] rot13(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if ((c >= 8'h61 && c <= 8'h6D) || (c >= 8'h41 && c <= 8'h4D)) begin
      r = c + ROT_AMOUNT;
    end else if ((c >= 8'h6E && c <= 8'h7A) || (c >= 8'h4E && c <= 8'h5A)) begin
      r = c - ROT_AMOUNT;
    end
    return r;
  endfunction

  // Standard base64 alphabet.
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage

// File: hdl/rxb_if.sv
interface rxb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;
  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface rxb_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] encoded_char;
  logic       last_char;
  modport source (output valid, output encoded_char, output last_char, input ready);
  modport sink (input valid, input encoded_char, input last_char, output ready);
endinterface

interface rxb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/rxb_cfg_regs.sv
module rxb_cfg_regs (
  input  logic        clk,
  input  logic        rst,
  rxb_cfg_if.sink     cfg,
  output logic [2:0]  key_length,
  output logic [31:0] key_bytes
);
  import rxb_pkg::*;

  assign cfg.ready = 1'b1;

  // Writes to an unknown index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= KEY_LENGTH_RESET;
      key_bytes  <= KEY_BYTES_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_KEY_LENGTH) begin
        key_length <= cfg.data[2:0];
      end else if (cfg.index == REG_KEY_BYTES) begin
        key_bytes <= cfg.data;
      end
    end
  end

endmodule

// File: hdl/rxb_encode.sv
module rxb_encode #(
  parameter int MAX_KEY_LEN = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         data_byte,
  input  logic               end_of_message,
  input  logic [2:0]         key_length,
  input  logic [31:0]        key_bytes,
  output rxb_pkg::rxb_group_t grp
);
  import rxb_pkg::*;

  localparam int PW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam logic [3:0] MAX_LEN = 4'(MAX_KEY_LEN);

  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;

  logic [PW-1:0] key_position, key_position_next;
  logic [1:0]    group_phase, group_phase_next;
  logic [3:0]    leftover_bits, leftover_bits_next;

  logic [3:0] len, pos, pos_inc;
  logic [7:0] kb, b;

  always_comb begin
    len = {1'b0, key_length};
    if (len == 4'd0) begin
      len = 4'd1;
    end
    if (len > MAX_LEN) begin
      len = MAX_LEN;
    end

    // A shrunken key length wraps the position before use.
    pos = 4'(key_position);
    if (pos >= len) begin
      pos = 4'd0;
    end
    kb = (pos < 4'd4) ? key_bytes[{pos[1:0], 3'b000} +: 8] : 8'h00;
    b  = rot13(data_byte) ^ kb;

    pos_inc = pos + 4'd1;
    key_position_next = (pos_inc >= len) ? '0 : pos_inc[PW-1:0];

    grp.chars = {GROUP_CHARS{PAD_CHAR}};
    grp.last  = end_of_message;
    case (group_phase)
      PH_1: begin
        grp.chars[0]       = b64_char({leftover_bits[1:0], b[7:4]});
        grp.cnt            = 3'd1;
        leftover_bits_next = b[3:0];
        group_phase_next   = PH_2;
      end
      PH_2: begin
        grp.chars[0]       = b64_char({leftover_bits, b[7:6]});
        grp.chars[1]       = b64_char(b[5:0]);
        grp.cnt            = 3'd2;
        leftover_bits_next = 4'd0;
        group_phase_next   = PH_0;
      end
      default: begin
        grp.chars[0]       = b64_char(b[7:2]);
        grp.cnt            = 3'd1;
        leftover_bits_next = {2'b00, b[1:0]};
        group_phase_next   = PH_1;
      end
    endcase

    // The final byte flushes pending bits and pads the group.
    if (end_of_message) begin
      case (group_phase_next)
        PH_1: begin
          grp.chars[1] = b64_char({leftover_bits_next[1:0], 4'b0000});
          grp.cnt      = 3'd4;
        end
        PH_2: begin
          grp.chars[1] = b64_char({leftover_bits_next, 2'b00});
          grp.cnt      = 3'd3;
        end
        default: begin
          grp.cnt = grp.cnt;
        end
      endcase
      key_position_next  = '0;
      group_phase_next   = PH_0;
      leftover_bits_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_position  <= '0;
      group_phase   <= PH_0;
      leftover_bits <= 4'd0;
    end else if (take) begin
      key_position  <= key_position_next;
      group_phase   <= group_phase_next;
      leftover_bits <= leftover_bits_next;
    end
  end

endmodule

// File: hdl/rxb_char_out.sv
module rxb_char_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                load_valid,
  input  rxb_pkg::rxb_group_t grp,
  output logic                can_load,
  rxb_char_if.source          enc
);
  import rxb_pkg::*;

  logic [GROUP_CHARS-1:0][7:0] chars;
  logic [2:0] cnt;
  logic [1:0] idx;
  logic       last;
  logic       take, final_take, at_end;

  assign at_end     = ({1'b0, idx} + 3'd1) == cnt;
  assign take       = enc.valid && enc.ready;
  assign final_take = take && at_end;
  assign can_load   = (cnt == 3'd0) || final_take;

  assign enc.valid        = cnt != 3'd0;
  assign enc.encoded_char = chars[idx];
  assign enc.last_char    = last && at_end;

  always_ff @(posedge clk) begin
    if (load_valid && can_load) begin
      chars <= grp.chars;
      last  <= grp.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
      idx <= 2'd0;
    end else if (load_valid && can_load) begin
      cnt <= grp.cnt;
      idx <= 2'd0;
    end else if (final_take) begin
      cnt <= 3'd0;
      idx <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

// File: hdl/rot13_xor_base64_encoder.sv
// The first character of a byte appears in the cycle after its message byte transaction.
// Throughput: one byte per cycle when each byte yields one character and the
// receiver is ready; a byte that yields more (up to four for a message's final byte)
// holds off the next until the single-character output channel has taken them all.
// Reset (rst, synchronous, active high) restores the key registers to "!@#" with
// length 3 and clears the key position, group phase, leftover bits and output buffer.
module rot13_xor_base64_encoder #(
  parameter int MAX_KEY_LEN = 4
) (
  input logic        clk,
  input logic        rst,
  rxb_byte_if.sink   msg,
  rxb_char_if.source enc,
  rxb_cfg_if.sink    cfg
);
  import rxb_pkg::*;

  logic [2:0]  key_length;
  logic [31:0] key_bytes;
  logic        can_load;
  logic        take;
  rxb_group_t  grp;

  // Configuration registers. The user is to write only while the block is idle, which
  // the block does not enforce; a new key then applies from the next byte on.
  rxb_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .key_length (key_length),
    .key_bytes  (key_bytes)
  );

  // A byte transaction is taken whenever the output buffer is empty or is
  // handing over its final character in this same cycle.
  assign msg.ready = can_load;
  assign take      = msg.valid && can_load;

  // Rotation, key XOR and base64 grouping, with the running state registers.
  rxb_encode #(
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_encode (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .data_byte      (msg.data_byte),
    .end_of_message (msg.end_of_message),
    .key_length     (key_length),
    .key_bytes      (key_bytes),
    .grp            (grp)
  );

  // Result register: holds the characters of one byte and serializes them
  // onto the output channel, one transaction per character.
  rxb_char_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (msg.valid),
    .grp        (grp),
    .can_load   (can_load),
    .enc        (enc)
  );

endmodule

// File: tb/rot13_xor_base64_encoder_tb.sv
module rot13_xor_base64_encoder_tb;
  import rxb_pkg::*;

  // The block under test is built with the default number of key slots.
  localparam int KEY_SLOTS = 4;
  // Index values that name no register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  // Cycles without any transaction before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Length of the long receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 26;

  // Flow control of one phase: who idles, and how often.
  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SRC_IDLE,
    FLOW_SNK_STALL,
    FLOW_BOTH
  } flow_t;

  // Tracks the scrambler and encoder state and holds the characters that the
  // block still owes, oldest first.
  class cipher_text_board;
    typedef struct packed {
      logic [7:0] ch;
      logic       fin;
    } enc_char_t;

    enc_char_t  awaited[$];
    logic [2:0] key_len;
    logic [31:0] key;
    int         key_pos;
    int         phase;
    logic [3:0] carry;
    int         mismatches;
    string      alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    function new();
      key_len    = KEY_LENGTH_RESET;
      key        = KEY_BYTES_RESET;
      key_pos    = 0;
      phase      = 0;
      carry      = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      if (idx == REG_KEY_LENGTH) begin
        key_len = val[2:0];
      end else if (idx == REG_KEY_BYTES) begin
        key = val;
      end
    endfunction

    function void put_char(logic [7:0] ch);
      enc_char_t c;
      c.ch  = ch;
      c.fin = 1'b0;
      awaited.push_back(c);
    endfunction

    function void put_sextet(logic [5:0] v);
      put_char(alphabet[v]);
    endfunction

    // Works out the characters that one accepted byte produces.
    function void take_byte(logic [7:0] raw, logic eom);
      logic [7:0] b;
      int span;
      int slot;
      span = key_len;
      if (span < 1) begin
        span = 1;
      end
      if (span > KEY_SLOTS) begin
        span = KEY_SLOTS;
      end
      slot = (key_pos >= span) ? 0 : key_pos;
      b = raw;
      if ((raw >= 8'h61 && raw <= 8'h6D) || (raw >= 8'h41 && raw <= 8'h4D)) begin
        b = raw + ROT_AMOUNT;
      end else if ((raw >= 8'h6E && raw <= 8'h7A) || (raw >= 8'h4E && raw <= 8'h5A)) begin
        b = raw - ROT_AMOUNT;
      end
      b = b ^ key[8*slot +: 8];
      key_pos = (slot + 1 >= span) ? 0 : slot + 1;
      case (phase)
        1: begin
          put_sextet({carry[1:0], b[7:4]});
          carry = b[3:0];
          phase = 2;
        end
        2: begin
          put_sextet({carry, b[7:6]});
          put_sextet(b[5:0]);
          carry = '0;
          phase = 0;
        end
        default: begin
          put_sextet(b[7:2]);
          carry = {2'b00, b[1:0]};
          phase = 1;
        end
      endcase
      if (eom) begin
        if (phase == 1) begin
          put_sextet({carry[1:0], 4'b0000});
          put_char(PAD_CHAR);
          put_char(PAD_CHAR);
        end else if (phase == 2) begin
          put_sextet({carry, 2'b00});
          put_char(PAD_CHAR);
        end
        awaited[awaited.size()-1].fin = 1'b1;
        key_pos = 0;
        phase   = 0;
        carry   = '0;
      end
    endfunction

    function void match_char(logic [7:0] ch, logic fin);
      enc_char_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected character got %h last_char %b", $time, ch, fin);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (want.ch !== ch) begin
        $display("%0t: encoded_char expected %h got %h", $time, want.ch, ch);
        mismatches++;
      end
      if (want.fin !== fin) begin
        $display("%0t: last_char expected %b got %b", $time, want.fin, fin);
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  rxb_byte_if msg ();
  rxb_char_if enc ();
  rxb_cfg_if  cfg ();

  rot13_xor_base64_encoder #(
    .MAX_KEY_LEN(KEY_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .msg(msg),
    .enc(enc),
    .cfg(cfg)
  );

  cipher_text_board book;
  flow_t flow = FLOW_FREE;
  // Bytes left in the message that the random stimulus is building.
  int msg_left = 0;
  // Set by the stimulus to request one long receiver hold-off.
  bit hold_request = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  // Receiver side. The ready line only changes at the falling edge. A long
  // hold-off is counted here, independent of the sender, so the block fills
  // its output buffer and has to push back on the message channel.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      enc.ready <= 1'b0;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      enc.ready <= 1'b0;
    end else begin
      case (flow)
        FLOW_SNK_STALL: enc.ready <= ($urandom_range(99) >= 74);
        FLOW_BOTH:      enc.ready <= ($urandom_range(99) >= 25);
        default:        enc.ready <= 1'b1;
      endcase
    end
  end

  // Every character transaction is checked against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && enc.valid && enc.ready) begin
      book.match_char(enc.encoded_char, enc.last_char);
    end
  end

  // Hang detection: any transaction on any channel restarts the count.
  always @(posedge clk) begin
    if ((msg.valid && msg.ready) || (enc.valid && enc.ready) || (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bit sender_idles();
    case (flow)
      FLOW_SRC_IDLE: return $urandom_range(99) < 74;
      FLOW_BOTH:     return $urandom_range(99) < 25;
      default:       return 1'b0;
    endcase
  endfunction

  // Offers one byte, keeping valid high from one byte to the next when the
  // sender does not idle, and hands it to the scoreboard once it is taken.
  task automatic send_byte(input logic [7:0] b, input logic eom);
    @(negedge clk);
    while (sender_idles()) begin
      msg.valid <= 1'b0;
      @(negedge clk);
    end
    msg.valid          <= 1'b1;
    msg.data_byte      <= b;
    msg.end_of_message <= eom;
    @(posedge clk);
    while (!msg.ready) begin
      @(posedge clk);
    end
    book.take_byte(b, eom);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) begin
      @(posedge clk);
    end
    book.set_reg(idx, val);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Stops offering bytes, waits for every owed character and then keeps watching so
  // that a stray extra character would still be caught. Register writes only happen
  // after this.
  task automatic drain();
    @(negedge clk);
    msg.valid <= 1'b0;
    while (book.pending() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Half of the bytes are letters so that the rotation is well exercised.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0:       return 8'h61 + 8'($urandom_range(25));
      1:       return 8'h41 + 8'($urandom_range(25));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Messages are mostly short, with an occasional long one; phases may end
  // in the middle of a message, so state carries across register writes.
  function automatic logic next_eom();
    if (msg_left == 0) begin
      msg_left = ($urandom_range(9) == 0) ? $urandom_range(24, 10) : $urandom_range(6, 1);
    end
    msg_left--;
    return msg_left == 0;
  endfunction

  initial begin
    int lens[8];
    book = new();
    lens = '{1, 4, 0, 7, 2, 5, 3, 6};
    clk = 1'b0;
    rst = 1'b1;
    msg.valid = 1'b0;
    msg.data_byte = '0;
    msg.end_of_message = 1'b0;
    enc.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, with the key left at its reset value first.
    // A one-byte message needs two pad characters.
    send_byte(8'h41, 1'b1);
    // Two bytes, the extremes, need one pad character.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Three bytes close a full group with no padding.
    send_byte(8'h7A, 1'b0);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h6E, 1'b1);
    // Letter range edges and their neighbors that must pass unrotated.
    send_byte(8'h61, 1'b0);
    send_byte(8'h6D, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h7A, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h5B, 1'b0);
    send_byte(8'h60, 1'b0);
    send_byte(8'h7B, 1'b1);
    drain();

    // Shrink the key in the middle of a message: the key position (three)
    // is past the new length and must wrap to the first key byte.
    write_reg(REG_KEY_LENGTH, 32'd4);
    write_reg(REG_KEY_BYTES, 32'hFFFF_FFFF);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    drain();
    write_reg(REG_KEY_LENGTH, 32'd2);
    send_byte(8'h78, 1'b0);
    send_byte(8'h9A, 1'b1);
    drain();

    // A key length of zero acts as one; upper data bits are not stored.
    write_reg(REG_KEY_LENGTH, 32'hFFFF_FFF8);
    write_reg(REG_KEY_BYTES, 32'hA5C3_3C5A);
    send_byte(8'hC6, 1'b0);
    send_byte(8'h39, 1'b1);
    drain();
    // Writes to unused indexes are ignored; a length above four acts as four.
    write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_B, 32'h0000_0001);
    write_reg(REG_KEY_LENGTH, 32'd7);
    send_byte(8'h5E, 1'b0);
    send_byte(8'h21, 1'b1);
    drain();

    // Random phases, stepping through every flow-control mode twice and
    // through every key length, with all-zero and all-one keys among them.
    for (int ph = 0; ph < 8; ph++) begin
      flow = flow_t'(ph % 4);
      write_reg(REG_KEY_LENGTH, {29'($urandom_range(32'h1FFF_FFFF)), 3'(lens[ph])});
      case (ph % 4)
        0:       write_reg(REG_KEY_BYTES, 32'h0000_0000);
        1:       write_reg(REG_KEY_BYTES, 32'hFFFF_FFFF);
        default: write_reg(REG_KEY_BYTES, $urandom());
      endcase
      if (ph % 2 == 1) begin
        write_reg(($urandom_range(1) == 0) ? REG_SPARE_A : REG_SPARE_B, $urandom());
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_byte(pick_byte(), next_eom());
      end
      // The sender waits here until every owed character has come out.
      drain();
    end

    // Back-pressure: the receiver holds off for a long stretch while the
    // sender keeps offering bytes back to back, so the block must stall
    // the message channel until the receiver lets go.
    flow = FLOW_FREE;
    write_reg(REG_KEY_LENGTH, 32'd3);
    write_reg(REG_KEY_BYTES, $urandom());
    @(posedge clk);
    hold_request = 1'b1;
    for (int i = 0; i < 30; i++) begin
      send_byte(pick_byte(), (i == 29) ? 1'b1 : next_eom());
    end
    drain();

    repeat (8) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
